// File: rtl/plti_pkg.sv
// plti_pkg: shared widths and types for the plane / triangle intersection pipeline
// no dependencies
package plti_pkg;

    localparam int CW        = 32;          // coordinate width
    localparam int NORM_FRAC = 30;          // fraction bits of the normal
    localparam int PW        = 2 * CW;      // one normal * coordinate product
    localparam int DW        = PW + 2;      // signed vertex distance
    localparam int NDW       = DW;          // distance magnitude
    localparam int NNW       = DW + 1;      // |d0 - d1|
    localparam int HW        = NDW / 2;     // split of the distance magnitude
    localparam int NUMW      = CW + NDW;    // dividend
    localparam int QW        = CW;          // quotient bits
    localparam int DIV_LAT   = QW + 1;
    localparam int DIST_LAT  = 2;
    localparam int EDGE_LAT  = 4;

    typedef enum logic [1:0] {
        CFG_NX = 2'd0,
        CFG_NY = 2'd1,
        CFG_NZ = 2'd2,
        CFG_W  = 2'd3
    } cfg_idx_t;

    typedef logic [2:0][CW-1:0] vec_t;      // [0] x, [1] y, [2] z

    typedef struct packed {
        logic [NUMW-1:0] num;
        logic [CW-1:0]   p0;
        logic            neg;
    } div_req_t;

    typedef struct packed {
        logic [NNW-1:0]     nn;
        div_req_t [2:0]     ax;
    } xing_t;

endpackage

// File: rtl/plti_dist.sv
// plti_dist: signed plane distance of the three vertices, two register stages
// depends on plti_pkg
module plti_dist import plti_pkg::*; (
    input  logic                 aclk,
    input  logic                 adv,
    input  logic [CW-1:0]        nx,
    input  logic [CW-1:0]        ny,
    input  logic [CW-1:0]        nz,
    input  logic [CW-1:0]        w,
    input  vec_t                 vin [3],
    output logic signed [DW-1:0] pdist [3],
    output vec_t                 vout [3]
);

    logic signed [PW-1:0] prod_reg [3][3];
    logic [CW-1:0]        w_reg;
    vec_t                 v1_reg [3];
    vec_t                 v2_reg [3];
    logic signed [DW-1:0] d_reg [3];
    logic [CW-1:0]        nv [3];

    assign nv[0] = nx;
    assign nv[1] = ny;
    assign nv[2] = nz;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    prod_reg[i][k] <= PW'($signed(nv[k])) * PW'($signed(vin[i][k]));
                end
                v1_reg[i] <= vin[i];
                d_reg[i]  <= DW'(prod_reg[i][0]) + DW'(prod_reg[i][1])
                           + DW'(prod_reg[i][2]) + (DW'($signed(w_reg)) <<< NORM_FRAC);
                v2_reg[i] <= v1_reg[i];
            end
            w_reg <= w;
        end
    end

    assign pdist = d_reg;
    assign vout  = v2_reg;

endmodule

// File: rtl/plti_edge.sv
// plti_edge: picks the two crossing edges and builds the rounded dividends
// four register stages; depends on plti_pkg
module plti_edge import plti_pkg::*; (
    input  logic                 aclk,
    input  logic                 adv,
    input  logic signed [DW-1:0] pdist [3],
    input  vec_t                 vin [3],
    output xing_t [1:0]          xs,
    output logic                 hit
);

    // stage 3
    vec_t                 p0_3 [2];
    logic signed [CW:0]   dl_3 [2][3];
    logic signed [DW-1:0] d0_3 [2];
    logic signed [NNW-1:0] dd_3 [2];
    logic                 hit_3;
    // stage 4
    vec_t                 p0_4 [2];
    logic [CW-1:0]        md_4 [2][3];
    logic                 neg_4 [2][3];
    logic [NDW-1:0]       nd_4 [2];
    logic [NNW-1:0]       nn_4 [2];
    logic                 hit_4;
    // stage 5
    vec_t                 p0_5 [2];
    logic [CW+HW-1:0]     plo_5 [2][3];
    logic [CW+HW-1:0]     phi_5 [2][3];
    logic                 neg_5 [2][3];
    logic [NNW-2:0]       half_5 [2];
    logic [NNW-1:0]       nn_5 [2];
    logic                 hit_5;
    // stage 6
    xing_t [1:0]          xs_reg;
    logic                 hit_reg;

    logic [2:0] sgn;
    logic [2:0] cx;
    logic [1:0] sel [2];
    logic [1:0] i1 [2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sgn[i] = pdist[i][DW-1];
        end
        cx[0] = sgn[0] ^ sgn[1];
        cx[1] = sgn[1] ^ sgn[2];
        cx[2] = sgn[2] ^ sgn[0];
        sel[0] = cx[0] ? 2'd0 : 2'd1;
        sel[1] = (cx[0] && cx[1]) ? 2'd1 : 2'd2;
        for (int g = 0; g < 2; g++) begin
            i1[g] = (sel[g] == 2'd2) ? 2'd0 : sel[g] + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hit_3 <= |cx;
            hit_4 <= hit_3;
            hit_5 <= hit_4;
            hit_reg <= hit_5;
            for (int g = 0; g < 2; g++) begin
                p0_3[g] <= vin[sel[g]];
                d0_3[g] <= pdist[sel[g]];
                dd_3[g] <= NNW'(pdist[sel[g]]) - NNW'(pdist[i1[g]]);
                nd_4[g] <= d0_3[g][DW-1] ? NDW'(-d0_3[g]) : NDW'(d0_3[g]);
                nn_4[g] <= dd_3[g][NNW-1] ? NNW'(-dd_3[g]) : NNW'(dd_3[g]);
                p0_4[g] <= p0_3[g];
                half_5[g] <= nn_4[g][NNW-1:1];
                nn_5[g] <= nn_4[g];
                p0_5[g] <= p0_4[g];
                xs_reg[g].nn <= nn_5[g];
                for (int k = 0; k < 3; k++) begin
                    dl_3[g][k] <= (CW+1)'($signed(vin[i1[g]][k]))
                                - (CW+1)'($signed(vin[sel[g]][k]));
                    md_4[g][k]  <= dl_3[g][k][CW] ? CW'(-dl_3[g][k]) : CW'(dl_3[g][k]);
                    neg_4[g][k] <= dl_3[g][k][CW];
                    plo_5[g][k] <= (CW+HW)'(md_4[g][k]) * (CW+HW)'(nd_4[g][HW-1:0]);
                    phi_5[g][k] <= (CW+HW)'(md_4[g][k]) * (CW+HW)'(nd_4[g][NDW-1:HW]);
                    neg_5[g][k] <= neg_4[g][k];
                    xs_reg[g].ax[k].num <= NUMW'(plo_5[g][k]) + (NUMW'(phi_5[g][k]) << HW)
                                         + NUMW'(half_5[g]);
                    xs_reg[g].ax[k].p0  <= p0_5[g][k];
                    xs_reg[g].ax[k].neg <= neg_5[g][k];
                end
            end
        end
    end

    assign xs  = xs_reg;
    assign hit = hit_reg;

endmodule

// File: rtl/plti_div.sv
// plti_div: pipelined restoring divider, one quotient bit per stage, then p0 + signed offset
// depends on plti_pkg
module plti_div import plti_pkg::*; (
    input  logic           aclk,
    input  logic           adv,
    input  div_req_t       req,
    input  logic [NNW-1:0] den,
    output logic [CW-1:0]  pt
);

    logic [NNW-1:0] rem_reg [QW];
    logic [QW-1:0]  lo_reg  [QW];
    logic [QW-1:0]  q_reg   [QW];
    logic [NNW-1:0] den_reg [QW];
    logic [CW-1:0]  p0_reg  [QW];
    logic           neg_reg [QW];
    logic [CW-1:0]  pt_reg;

    for (genvar s = 0; s < QW; s++) begin : g_step
        logic [NNW-1:0] rem_in;
        logic [QW-1:0]  lo_in;
        logic [QW-1:0]  q_in;
        logic [NNW-1:0] den_in;
        logic [CW-1:0]  p0_in;
        logic           neg_in;
        logic [NNW:0]   t;
        logic           ge;

        if (s == 0) begin : g_first
            assign rem_in = NNW'(req.num[NUMW-1:QW]);
            assign lo_in  = req.num[QW-1:0];
            assign q_in   = '0;
            assign den_in = den;
            assign p0_in  = req.p0;
            assign neg_in = req.neg;
        end else begin : g_next
            assign rem_in = rem_reg[s-1];
            assign lo_in  = lo_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign den_in = den_reg[s-1];
            assign p0_in  = p0_reg[s-1];
            assign neg_in = neg_reg[s-1];
        end

        assign t  = {rem_in, lo_in[QW-1]};
        assign ge = t >= {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[s] <= ge ? NNW'(t - {1'b0, den_in}) : NNW'(t);
                lo_reg[s]  <= lo_in << 1;
                q_reg[s]   <= {q_in[QW-2:0], ge};
                den_reg[s] <= den_in;
                p0_reg[s]  <= p0_in;
                neg_reg[s] <= neg_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pt_reg <= p0_reg[QW-1] + (neg_reg[QW-1] ? CW'(-q_reg[QW-1]) : q_reg[QW-1]);
        end
    end

    assign pt = pt_reg;

endmodule

// File: rtl/plane_triangle_intersection.sv
// plane_triangle_intersection: top level, config registers, handshake and pipeline control
// depends on plti_pkg, plti_dist, plti_edge, plti_div
//
// Usage: load normal_x/y/z (Q2.30) and plane_offset (Q16.16) through the write
// port (cfg_wr_en, cfg_index, cfg_data) while no triangle is in flight. Each
// request on the s_ channel is one triangle of three Q16.16 vertices; each
// result on the m_ channel gives hit and the start and end crossing points,
// all zero when the plane misses.
// Pipeline: distance stages, edge stages, divider stages and a final add
// stage. Throughput: one triangle per cycle while the receiver takes results
// without stalling; the divider pipeline's quotient bit per stage sets the depth.
// Reset clears the plane registers and all valid bits; the pipe is empty.
// When the receiver stalls with a result pending, the whole pipe freezes and
// s_ready drops in the same cycle; nothing is lost or repeated.
module plane_triangle_intersection import plti_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [31:0]   s_a_x,
    input  logic [31:0]   s_a_y,
    input  logic [31:0]   s_a_z,
    input  logic [31:0]   s_b_x,
    input  logic [31:0]   s_b_y,
    input  logic [31:0]   s_b_z,
    input  logic [31:0]   s_c_x,
    input  logic [31:0]   s_c_y,
    input  logic [31:0]   s_c_z,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_hit,
    output logic [31:0]   m_start_x,
    output logic [31:0]   m_start_y,
    output logic [31:0]   m_start_z,
    output logic [31:0]   m_end_x,
    output logic [31:0]   m_end_y,
    output logic [31:0]   m_end_z
);

    localparam int LAT = DIST_LAT + EDGE_LAT + DIV_LAT;

    logic [CW-1:0]        nx_reg, ny_reg, nz_reg, w_reg;
    logic [LAT-1:0]       valid_reg;
    logic [DIV_LAT-1:0]   hit_reg;
    logic                 adv;
    vec_t                 vin [3];
    vec_t                 vdist [3];
    logic signed [DW-1:0] pdist [3];
    xing_t [1:0]          xs;
    logic                 edge_hit;
    logic [CW-1:0]        pt [2][3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nx_reg <= '0;
            ny_reg <= '0;
            nz_reg <= '0;
            w_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_NX:  nx_reg <= cfg_data;
                CFG_NY:  ny_reg <= cfg_data;
                CFG_NZ:  nz_reg <= cfg_data;
                CFG_W:   w_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign adv     = !valid_reg[LAT-1] || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[LAT-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hit_reg <= {hit_reg[DIV_LAT-2:0], edge_hit};
        end
    end

    assign vin[0] = {s_a_z, s_a_y, s_a_x};
    assign vin[1] = {s_b_z, s_b_y, s_b_x};
    assign vin[2] = {s_c_z, s_c_y, s_c_x};

    plti_dist u_dist (
        .aclk  (aclk),
        .adv   (adv),
        .nx    (nx_reg),
        .ny    (ny_reg),
        .nz    (nz_reg),
        .w     (w_reg),
        .vin   (vin),
        .pdist (pdist),
        .vout  (vdist)
    );

    plti_edge u_edge (
        .aclk  (aclk),
        .adv   (adv),
        .pdist (pdist),
        .vin   (vdist),
        .xs    (xs),
        .hit   (edge_hit)
    );

    for (genvar g = 0; g < 2; g++) begin : g_side
        for (genvar k = 0; k < 3; k++) begin : g_axis
            plti_div u_div (
                .aclk (aclk),
                .adv  (adv),
                .req  (xs[g].ax[k]),
                .den  (xs[g].nn),
                .pt   (pt[g][k])
            );
        end
    end

    assign m_valid   = valid_reg[LAT-1];
    assign m_hit     = hit_reg[DIV_LAT-1];
    assign m_start_x = m_hit ? pt[0][0] : '0;
    assign m_start_y = m_hit ? pt[0][1] : '0;
    assign m_start_z = m_hit ? pt[0][2] : '0;
    assign m_end_x   = m_hit ? pt[1][0] : '0;
    assign m_end_y   = m_hit ? pt[1][1] : '0;
    assign m_end_z   = m_hit ? pt[1][2] : '0;

endmodule

// File: rtl/plti_checker.sv
// plti_checker: port-level assertions for plane_triangle_intersection, bound to the top level
// depends on plane_triangle_intersection
module plti_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_hit,
    input logic [31:0] m_start_x,
    input logic [31:0] m_start_y,
    input logic [31:0] m_start_z,
    input logic [31:0] m_end_x,
    input logic [31:0] m_end_y,
    input logic [31:0] m_end_z
);

    // a miss carries zero coordinates
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_start_x == 0 && m_start_y == 0 && m_start_z == 0
                              && m_end_x == 0 && m_end_y == 0 && m_end_z == 0)
        else $error("miss with nonzero coordinates");

    // input side stalls only behind a blocked result
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow output stall");

    // empty pipe right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result after reset");

    // a blocked result holds its valid, hit, start x and end x
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_start_x)
                                && $stable(m_end_x))
        else $error("blocked result changed");

endmodule

bind plane_triangle_intersection plti_checker u_plti_checker (.*);

// File: test/tb_plane_triangle_intersection.sv
// tb_plane_triangle_intersection: self-checking bench for the plane / triangle cut
// depends on plti_pkg and plane_triangle_intersection; triangles checked against an exact model
module tb_plane_triangle_intersection;
    import plti_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic hit;
        vec_t s;
        vec_t e;
    } cut_t;

    class cut_scoreboard;
        logic signed [31:0] nx, ny, nz, w;
        cut_t expected_cuts[$];
        int errors;

        function new();
            nx = 0; ny = 0; nz = 0; w = 0;
            errors = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [31:0] val);
            case (idx)
                CFG_NX: nx = val;
                CFG_NY: ny = val;
                CFG_NZ: nz = val;
                CFG_W:  w = val;
                default: ;
            endcase
        endfunction

        function logic signed [127:0] plane_dist(vec_t p);
            logic signed [127:0] px, py, pz, sum;
            px = $signed(p[0]);
            py = $signed(p[1]);
            pz = $signed(p[2]);
            sum = px * 128'(nx) + py * 128'(ny) + pz * 128'(nz);
            sum = sum + (128'(w) <<< NORM_FRAC);
            return sum;
        endfunction

        function vec_t cross_point(vec_t p0, vec_t p1, logic signed [127:0] d0,
                                   logic signed [127:0] d1);
            logic [127:0] nd, nn, num, md;
            logic signed [127:0] diff;
            logic signed [63:0] a0, a1, del;
            logic [63:0] q;
            vec_t pt;
            nd = (d0 < 0) ? -d0 : d0;
            diff = d0 - d1;
            nn = (diff < 0) ? -diff : diff;
            for (int k = 0; k < 3; k++) begin
                a0 = $signed(p0[k]);
                a1 = $signed(p1[k]);
                del = a1 - a0;
                md = (del < 0) ? 128'(-del) : 128'(del);
                num = md * nd + (nn >> 1);
                q = 64'(num / nn);
                if (del < 0)
                    q = -q;
                pt[k] = 32'(a0 + $signed(q));
            end
            return pt;
        endfunction

        function void note(vec_t a, vec_t b, vec_t c);
            vec_t v[3];
            logic signed [127:0] d[3];
            cut_t r;
            int cnt;
            v[0] = a; v[1] = b; v[2] = c;
            r = '0;
            cnt = 0;
            for (int i = 0; i < 3; i++)
                d[i] = plane_dist(v[i]);
            for (int i = 0; i < 3; i++) begin
                if ((d[i] < 0) != (d[(i + 1) % 3] < 0)) begin
                    if (cnt == 0)
                        r.s = cross_point(v[i], v[(i + 1) % 3], d[i], d[(i + 1) % 3]);
                    else
                        r.e = cross_point(v[i], v[(i + 1) % 3], d[i], d[(i + 1) % 3]);
                    cnt++;
                end
            end
            r.hit = (cnt != 0);
            expected_cuts = {expected_cuts, r};
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check(cut_t got);
            cut_t exp_cut;
            if (expected_cuts.size() == 0) begin
                report("result with no request outstanding");
                return;
            end
            exp_cut = expected_cuts.pop_front();
            if (got.hit !== exp_cut.hit)
                report($sformatf("hit got %b exp %b", got.hit, exp_cut.hit));
            for (int k = 0; k < 3; k++) begin
                if (got.s[k] !== exp_cut.s[k])
                    report($sformatf("start[%0d] got %h exp %h", k, got.s[k], exp_cut.s[k]));
                if (got.e[k] !== exp_cut.e[k])
                    report($sformatf("end[%0d] got %h exp %h", k, got.e[k], exp_cut.e[k]));
            end
        endtask
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic s_valid = 0;
    logic s_ready;
    vec_t va = '0, vb = '0, vc = '0;
    logic m_valid;
    logic m_ready = 0;
    logic m_hit;
    vec_t ms, me;
    int tx_idle = 0;
    int rx_idle = 0;
    cut_scoreboard sb;

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    plane_triangle_intersection u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a_x(va[0]), .s_a_y(va[1]), .s_a_z(va[2]),
        .s_b_x(vb[0]), .s_b_y(vb[1]), .s_b_z(vb[2]),
        .s_c_x(vc[0]), .s_c_y(vc[1]), .s_c_z(vc[2]),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit),
        .m_start_x(ms[0]), .m_start_y(ms[1]), .m_start_z(ms[2]),
        .m_end_x(me[0]), .m_end_y(me[1]), .m_end_z(me[2])
    );

    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    // result side
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check({m_hit, ms, me});
            m_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        sb.set_reg(idx, val);
    endtask

    task automatic set_plane(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [31:0] off);
        write_reg(CFG_NX, x);
        write_reg(CFG_NY, y);
        write_reg(CFG_NZ, z);
        write_reg(CFG_W, off);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.expected_cuts.size() != 0)
            @(posedge aclk);
        repeat (45) @(posedge aclk);
    endtask

    task automatic send_tri(vec_t a, vec_t b, vec_t c);
        while ($urandom_range(99) < tx_idle) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        va <= a;
        vb <= b;
        vc <= c;
        do @(posedge aclk); while (!s_ready);
        sb.note(a, b, c);
    endtask

    function automatic logic [31:0] rand_reg();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return $urandom_range(32'h40000000) - 32'h20000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(7))
            0: return $urandom;
            1: return 32'h0;
            2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return $urandom_range(32'h00200000) - 32'h00100000;
        endcase
    endfunction

    function automatic vec_t rand_vec();
        vec_t v;
        for (int k = 0; k < 3; k++)
            v[k] = rand_coord();
        return v;
    endfunction

    function automatic vec_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        vec_t v;
        v[0] = x; v[1] = y; v[2] = z;
        return v;
    endfunction

    initial begin
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // plane x = 0
        set_plane(32'h40000000, 0, 0, 0);
        send_tri(mk(32'hffff0000, 0, 0), mk(32'h00010000, 0, 0), mk(0, 32'h00010000, 0));
        send_tri(mk(32'hfffe0000, 1, 2), mk(32'h00030000, 5, 7), mk(32'h00010000, 9, 3));
        send_tri(mk(0, 0, 0), mk(0, 32'h00010000, 0), mk(0, 0, 32'h00010000));
        send_tri(mk(1, 0, 0), mk(2, 3, 4), mk(5, 6, 7));
        send_tri(mk(32'hffffffff, 0, 0), mk(32'hfffffffe, 3, 4), mk(32'hfffffff0, 6, 7));
        send_tri(mk(32'h80000000, 32'h80000000, 32'h80000000),
                 mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff),
                 mk(32'h80000000, 32'h7fffffff, 0));
        send_tri(mk(32'h7fffffff, 32'h80000000, 32'h7fffffff),
                 mk(32'h80000000, 32'h7fffffff, 32'h80000000),
                 mk(0, 0, 0));
        send_tri(mk(32'hffff8000, 1, 1), mk(32'h00008000, 2, 2), mk(32'h00008000, 3, 3));
        send_tri(mk(0, 0, 0), mk(32'hffffffff, 32'h00010000, 0), mk(1, 0, 32'h00010000));
        drain();
        set_plane(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        send_tri(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff), mk(0, 0, 0),
                 mk(32'h80000000, 32'h80000000, 32'h80000000));
        send_tri(mk(32'h7fff0000, 0, 0), mk(32'h80000000, 0, 0), mk(0, 32'h7fffffff, 0));
        send_tri(mk(0, 0, 32'h7fffffff), mk(0, 0, 0), mk(32'h80000000, 1, 2));
        drain();
        set_plane(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff);
        send_tri(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff), mk(0, 0, 0),
                 mk(32'h80000000, 32'h80000000, 32'h80000000));
        send_tri(mk(32'h80000000, 0, 0), mk(32'h7fffffff, 0, 0), mk(5, 5, 5));
        send_tri(mk(0, 0, 0), mk(1, 1, 1), mk(2, 2, 2));
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle = (ph == 0) ? 32 : (ph == 1) ? 60 : 0;
            rx_idle = (ph == 0) ? 60 : (ph == 1) ? 32 : 0;
            for (int cs = 0; cs < 4; cs++) begin
                if (cs == 0)
                    set_plane(0, 32'h40000000, 0, rand_coord());
                else
                    set_plane(rand_reg(), rand_reg(), rand_reg(), rand_reg());
                for (int n = 0; n < 145; n++)
                    send_tri(rand_vec(), rand_vec(), rand_vec());
                s_valid <= 0;
                drain();
            end
        end
        set_plane(0, 0, 0, 0);
        send_tri(rand_vec(), rand_vec(), rand_vec());
        s_valid <= 0;
        drain();

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// File: plane_triangle_intersection.f
rtl/plti_pkg.sv
rtl/plti_dist.sv
rtl/plti_edge.sv
rtl/plti_div.sv
rtl/plane_triangle_intersection.sv
rtl/plti_checker.sv
test/tb_plane_triangle_intersection.sv
